[design/sorted_run_group_mean_stdev_defines.svh]
// Assertion macros shared by the sorted run grouping block.
// Include this header in files that hold concurrent assertions.
`ifndef SORTED_RUN_GROUP_MEAN_STDEV_DEFINES_SVH
`define SORTED_RUN_GROUP_MEAN_STDEV_DEFINES_SVH

// Implication check with an asynchronous active-low reset.
`define SRG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check with an asynchronous active-low reset.
`define SRG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/srg_pkg.sv]
// Shared types and constants of the sorted run grouping block.
// No dependencies.
package srg_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 24;
  localparam int unsigned SumW    = 40;
  localparam int unsigned SqW     = 64;
  localparam int unsigned CntW    = 16;
  localparam int unsigned CfgW    = 2;
  localparam int unsigned MaxCols = 3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accum;      // add the held row to the open group
    logic start_key;  // load the open key from the held row
    logic clear;      // close the open group
    logic col_start;  // begin arithmetic for one column
    logic [1:0] col;  // column under work
    logic col_use;    // column is in use
    logic out_load;   // move the finished group into the output register
  } srg_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic col_done;   // column arithmetic finished
    logic key_differ; // held row key differs from the open key
  } srg_sts_t;

endpackage

[design/srg_datapath.sv]
// Datapath: group accumulators, a shared sequential divider and square root,
// and the output register. Depends on srg_pkg.
module srg_datapath #(
  parameter int unsigned VALUE_COLUMNS = 3,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srg_pkg::srg_cmd_t              cmd_i,
  output srg_pkg::srg_sts_t              sts_o,
  input  logic signed [31:0]             row_key_i,
  input  logic signed [23:0]             value_a_i,
  input  logic signed [23:0]             value_b_i,
  input  logic signed [23:0]             value_c_i,
  input  logic                           load_row_i,
  output logic signed [31:0]             group_key_o,
  output logic [15:0]                    group_size_o,
  output logic signed [23:0]             mean_a_o,
  output logic signed [23:0]             mean_b_o,
  output logic signed [23:0]             mean_c_o,
  output logic [23:0]                    spread_a_o,
  output logic [23:0]                    spread_b_o,
  output logic [23:0]                    spread_c_o,
  output logic                           count_overflow_o
);
  import srg_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // Column arithmetic phases.
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhMean = 3'd1;
  localparam logic [2:0] PhMul  = 3'd2;
  localparam logic [2:0] PhVar  = 3'd3;
  localparam logic [2:0] PhSqrt = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  logic signed [31:0] hkey_q;
  logic signed [23:0] hval_q [MaxCols];
  logic signed [31:0] okey_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic ovf_q;
  logic signed [SumW-1:0] sum_q [MaxCols];
  logic [SqW-1:0] sq_q [MaxCols];

  // Held row register.
  always_ff @(posedge clk_i) begin
    if (load_row_i) begin
      hkey_q    <= row_key_i;
      hval_q[0] <= value_a_i;
      hval_q[1] <= value_b_i;
      hval_q[2] <= value_c_i;
    end
  end

  assign sts_o.key_differ = (hkey_q != okey_q);

  // Group accumulators; columns beyond VALUE_COLUMNS are never reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      okey_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      for (int j = 0; j < MaxCols; j++) begin
        sum_q[j] <= '0;
        sq_q[j]  <= '0;
      end
    end else if (cmd_i.clear) begin
      okey_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      for (int j = 0; j < MaxCols; j++) begin
        sum_q[j] <= '0;
        sq_q[j]  <= '0;
      end
    end else begin
      if (cmd_i.start_key) begin
        okey_q <= hkey_q;
      end
      if (cmd_i.accum) begin
        if (cnt_q == CntMax) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          for (int j = 0; j < MaxCols; j++) begin
            sum_q[j] <= sum_q[j] + SumW'(hval_q[j]);
            sq_q[j]  <= sq_q[j] + SqW'($unsigned(48'(hval_q[j]) * 48'(hval_q[j])));
          end
        end
      end
    end
  end

  // Shared column unit: restoring division for the mean, n*q - s^2 from
  // five 32-bit partial products, restoring division for the variance and a
  // bit-pair square root, one step per cycle.
  logic [2:0]   ph_q;
  logic [2:0]   mstep_q;
  logic [6:0]   step_q;
  logic [1:0]   col_q;
  logic [SumW-1:0] mag_q;
  logic         neg_q;
  logic [79:0]  acc_q;
  logic [79:0]  dvd_q;
  logic [31:0]  rem_q;
  logic [31:0]  dvs_q;
  logic signed [23:0] mean_q;
  logic [63:0]  sx_q, sres_q, sbit_q;

  logic [SumW-1:0] sum_mag;
  logic [31:0]  nn1;
  logic [32:0]  rem_sh;
  logic         qbit;
  logic [63:0]  sadd;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [79:0]  pp_sh;

  assign sum_mag = sum_q[cmd_i.col][SumW-1] ? SumW'(-sum_q[cmd_i.col]) : sum_q[cmd_i.col];
  assign nn1     = 32'(cnt_q) * 32'(cnt_q - 1'b1);
  assign rem_sh  = {rem_q, dvd_q[79]};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});
  assign sadd    = sres_q + sbit_q;

  // 32x32 partial product selected by step, then aligned.
  always_comb begin
    unique case (mstep_q)
      3'd0:    begin pa = sq_q[col_q][31:0];  pb = 32'(cnt_q); end
      3'd1:    begin pa = sq_q[col_q][63:32]; pb = 32'(cnt_q); end
      3'd2:    begin pa = 32'(mag_q[19:0]);   pb = 32'(mag_q[19:0]); end
      3'd3:    begin pa = 32'(mag_q[39:20]);  pb = 32'(mag_q[19:0]); end
      default: begin pa = 32'(mag_q[39:20]);  pb = 32'(mag_q[39:20]); end
    endcase
  end
  assign pp = pa * pb;

  always_comb begin
    unique case (mstep_q)
      3'd0, 3'd2: pp_sh = {16'd0, pp};
      3'd1:       pp_sh = {pp[47:0], 32'd0};
      3'd3:       pp_sh = {pp[58:0], 21'd0};
      3'd4:       pp_sh = {pp[39:0], 40'd0};
      default:    pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle;
    end else begin
      unique case (ph_q)
        PhIdle: if (cmd_i.col_start) ph_q <= PhMean;
        PhMean: if (step_q == 7'd0) ph_q <= PhMul;
        PhMul:  if (mstep_q == 3'd5) ph_q <= PhVar;
        PhVar:  if (step_q == 7'd0) ph_q <= PhSqrt;
        PhSqrt: if (sbit_q == 64'd0) ph_q <= PhDone;
        PhDone: ph_q <= PhIdle;
        default: ph_q <= PhIdle;
      endcase
    end
  end

  assign sts_o.col_done = (ph_q == PhDone);

  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      PhIdle: if (cmd_i.col_start) begin
        col_q   <= cmd_i.col;
        mag_q   <= sum_mag;
        neg_q   <= sum_q[cmd_i.col][SumW-1];
        dvd_q   <= {sum_mag, 40'd0};
        rem_q   <= '0;
        dvs_q   <= 32'(cnt_q);
        step_q  <= 7'd40;
        mstep_q <= 3'd0;
      end
      PhMean, PhVar: begin
        // Quotient bits shift in as dividend bits shift out.
        if (step_q != 7'd0) begin
          dvd_q  <= {dvd_q[78:0], qbit};
          rem_q  <= qbit ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
          step_q <= step_q - 1'b1;
        end else if (ph_q == PhMean) begin
          mean_q <= neg_q ? (24'd0 - dvd_q[23:0]) : dvd_q[23:0];
        end else begin
          sx_q   <= (dvd_q[79:64] != 16'd0) ? '1 : dvd_q[63:0];
          sres_q <= '0;
          sbit_q <= 64'd1 << 62;
        end
      end
      PhMul: begin
        // acc = n*q - mag^2; a negative difference gives a zero variance.
        if (mstep_q == 3'd5) begin
          dvd_q  <= acc_q[79] ? '0 : acc_q;
          rem_q  <= '0;
          dvs_q  <= nn1;
          step_q <= 7'd80;
        end else if (mstep_q == 3'd0) begin
          acc_q <= pp_sh;
        end else if (mstep_q == 3'd1) begin
          acc_q <= acc_q + pp_sh;
        end else begin
          acc_q <= acc_q - pp_sh;
        end
        mstep_q <= mstep_q + 1'b1;
      end
      PhSqrt: begin
        if (sbit_q != 64'd0) begin
          if (sx_q >= sadd) begin
            sx_q   <= sx_q - sadd;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      default: ;
    endcase
  end

  // Per-column results gathered before the output register.
  logic signed [23:0] mres_q [MaxCols];
  logic [23:0] sres_col_q [MaxCols];
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_start) begin
      mres_q[cmd_i.col]     <= '0;
      sres_col_q[cmd_i.col] <= '0;
    end
    if (ph_q == PhDone && cmd_i.col_use && cnt_q != '0 && 32'(col_q) < VALUE_COLUMNS) begin
      mres_q[col_q]     <= mean_q;
      sres_col_q[col_q] <= (cnt_q < 2) ? 24'd0 :
                           ((sres_q > 64'hFFFFFF) ? 24'hFFFFFF : 24'(sres_q));
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      group_key_o      <= okey_q;
      group_size_o     <= 16'(cnt_q);
      mean_a_o         <= mres_q[0];
      mean_b_o         <= mres_q[1];
      mean_c_o         <= mres_q[2];
      spread_a_o       <= sres_col_q[0];
      spread_b_o       <= sres_col_q[1];
      spread_c_o       <= sres_col_q[2];
      count_overflow_o <= ovf_q;
    end
  end
endmodule

[design/srg_ctrl.sv]
// Controller: sequences row intake, group closing and per-column arithmetic.
// Depends on srg_pkg.
module srg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_acc_i,
  input  logic              final_row_i,
  input  logic [1:0]        cols_i,
  input  logic              out_take_i,
  input  srg_pkg::srg_sts_t sts_i,
  output srg_pkg::srg_cmd_t cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output logic              out_last_o
);
  import srg_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StCol   = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StAdd   = 3'd5;

  logic [2:0] st_q, st_d;
  logic open_q, open_d, fin_q, fin_d, last_q, last_d, ov_q, ov_d, ol_q, ol_d;
  logic [1:0] col_q, col_d;

  always_comb begin
    st_d = st_q; open_d = open_q; fin_d = fin_q; last_d = last_q;
    col_d = col_q; ov_d = ov_q; ol_d = ol_q;
    cmd_o = '0;
    cmd_o.col = col_q;
    cmd_o.col_use = (col_q < cols_i);
    if (out_take_i) ov_d = 1'b0;
    unique case (st_q)
      StIdle: if (in_acc_i) begin
        fin_d = final_row_i;
        st_d  = StCheck;
      end
      StCheck: begin
        if (open_q && sts_i.key_differ) begin
          last_d = 1'b0; col_d = 2'd0; st_d = StCol;
        end else st_d = StAdd;
      end
      StAdd: begin
        if (!open_q) cmd_o.start_key = 1'b1;
        cmd_o.accum = 1'b1;
        open_d = 1'b1;
        if (fin_q) begin
          fin_d = 1'b0; last_d = 1'b1; col_d = 2'd0; st_d = StCol;
        end else st_d = StIdle;
      end
      StCol: begin
        cmd_o.col_start = 1'b1; st_d = StWait;
      end
      StWait: if (sts_i.col_done) begin
        if (col_q == 2'd2) st_d = StEmit;
        else begin col_d = col_q + 1'b1; st_d = StCol; end
      end
      StEmit: if (!ov_q || out_take_i) begin
        cmd_o.out_load = 1'b1;
        cmd_o.clear = 1'b1; open_d = 1'b0;
        ov_d = 1'b1; ol_d = last_q;
        st_d = last_q ? StIdle : StAdd;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; open_q <= 1'b0; fin_q <= 1'b0; last_q <= 1'b0;
      col_q <= '0; ov_q <= 1'b0; ol_q <= 1'b0;
    end else begin
      st_q <= st_d; open_q <= open_d; fin_q <= fin_d; last_q <= last_d;
      col_q <= col_d; ov_q <= ov_d; ol_q <= ol_d;
    end
  end

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_last_o  = ol_q;
endmodule

[design/sorted_run_group_mean_stdev.sv]
// Groups adjacent rows with equal keys and reports count, mean and sample
// standard deviation per column. No new row is taken while one is in work.
// Each group a row closes runs all three columns in turn on the shared
// bit-serial divider and square-root unit, plus any wait for the output
// register to be taken; a row may close two.
module sorted_run_group_mean_stdev #(
  parameter int unsigned VALUE_COLUMNS = 3,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] row_key_i,
  input  logic signed [23:0] value_a_i,
  input  logic signed [23:0] value_b_i,
  input  logic signed [23:0] value_c_i,
  input  logic               final_row_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] group_key_o,
  output logic [15:0]        group_size_o,
  output logic signed [23:0] mean_a_o,
  output logic signed [23:0] mean_b_o,
  output logic signed [23:0] mean_c_o,
  output logic [23:0]        spread_a_o,
  output logic [23:0]        spread_b_o,
  output logic [23:0]        spread_c_o,
  output logic               count_overflow_o,
  output logic               last_group_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import srg_pkg::*;
  `include "sorted_run_group_mean_stdev_defines.svh"

  srg_cmd_t cmd;
  srg_sts_t sts;
  logic in_acc, out_take;
  logic [1:0] cols_q;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Column count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cols_q <= 2'd3;
    else if (cfg_valid && cfg_ready) cols_q <= cfg_data;
  end

  srg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_acc_i(in_acc), .final_row_i, .cols_i(cols_q),
    .out_take_i(out_take), .sts_i(sts), .cmd_o(cmd), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_last_o(last_group_o)
  );

  srg_datapath #(.VALUE_COLUMNS(VALUE_COLUMNS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .row_key_i, .value_a_i,
    .value_b_i, .value_c_i, .load_row_i(in_acc),
    .group_key_o, .group_size_o, .mean_a_o, .mean_b_o, .mean_c_o,
    .spread_a_o, .spread_b_o, .spread_c_o, .count_overflow_o
  );

  // An accepted item is never taken while another is in work.
  `SRG_ASSERT_NXT(a_no_double_accept, clk_i, rst_ni, in_acc, in_stall)
  // A result is never overwritten before it is taken.
  `SRG_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid || out_take)
  // A reported group has at least one row.
  `SRG_ASSERT_IMP(a_size_nonzero, clk_i, rst_ni, out_valid, group_size_o != 16'd0)
endmodule

[tb/sv/tb.sv]
// Testbench for the sorted run grouping block: drives rows, predicts group statistics.
// Depends on srg_pkg and sorted_run_group_mean_stdev; needs no other file.
module tb;
  import srg_pkg::*;

  typedef struct {
    bit [31:0] key;
    bit [23:0] val [3];
    bit        fin;
  } row_t;

  typedef struct {
    bit [31:0] key;
    bit [15:0] size;
    bit [23:0] mean [3];
    bit [23:0] spread [3];
    bit        ovf;
    bit        is_last;
  } group_t;

  // Running group statistics and the queue of groups still to come out.
  class group_stats_board;
    bit [1:0]    cols = 2'd3;
    bit          open;
    bit [31:0]   open_key;
    int unsigned cnt;
    bit          ovf;
    longint      sums [3];
    bit [63:0]   sq_sums [3];
    group_t      awaited [$];
    int          errors;
    int          groups_seen;

    task report(string what, bit [63:0] got, bit [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    function void clear();
      open = 0;
      open_key = 0;
      cnt = 0;
      ovf = 0;
      for (int j = 0; j < 3; j++) begin
        sums[j] = 0;
        sq_sums[j] = 0;
      end
    endfunction

    function bit [63:0] root_floor(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] step;
      res = 0;
      step = 64'd1 << 62;
      while (step > x) step >>= 2;
      while (step != 0) begin
        if (x >= res + step) begin
          x -= res + step;
          res = (res >> 1) + step;
        end else begin
          res >>= 1;
        end
        step >>= 2;
      end
      return res;
    endfunction

    // Sample deviation from count, sum and sum of squares.
    function bit [23:0] deviation(int unsigned n, longint s, bit [63:0] q);
      bit [127:0] nq;
      bit [127:0] ss;
      bit [127:0] diff;
      bit [127:0] div;
      bit [127:0] quo;
      bit [63:0]  mag;
      bit [63:0]  variance;
      bit [63:0]  r;
      if (n < 2) return 0;
      nq = 128'(q) * 128'(n);
      mag = (s < 0) ? 64'(-s) : 64'(s);
      ss = 128'(mag) * 128'(mag);
      diff = nq - ss;
      if (diff[127]) return 0;
      div = 128'(n) * 128'(n - 1);
      quo = diff / div;
      variance = (quo[127:64] != 0) ? '1 : quo[63:0];
      r = root_floor(variance);
      return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    endfunction

    function void emit(bit is_last);
      group_t g;
      g.key = open_key;
      g.size = cnt[15:0];
      for (int j = 0; j < 3; j++) begin
        g.mean[j] = 0;
        g.spread[j] = 0;
        if (j < cols && cnt != 0) begin
          g.mean[j] = 24'(sums[j] / longint'(cnt));
          g.spread[j] = deviation(cnt, sums[j], sq_sums[j]);
        end
      end
      g.ovf = ovf;
      g.is_last = is_last;
      awaited.insert(awaited.size(), g);
    endfunction

    // Update the open group with an accepted row.
    function void note_row(row_t r);
      longint v;
      bit [63:0] mag;
      if (open && r.key != open_key) begin
        emit(0);
        clear();
      end
      if (!open) begin
        open = 1;
        open_key = r.key;
      end
      if (cnt >= (1 << 16) - 1) begin
        ovf = 1;
      end else begin
        cnt++;
        for (int j = 0; j < 3; j++) begin
          v = longint'($signed(r.val[j]));
          mag = (v < 0) ? 64'(-v) : 64'(v);
          sums[j] += v;
          sq_sums[j] += mag * mag;
        end
      end
      if (r.fin) begin
        emit(1);
        clear();
      end
    endfunction

    task check_group(group_t g);
      group_t w;
      groups_seen++;
      if (awaited.size() == 0) begin
        report("unexpected group key", g.key, 0);
        return;
      end
      w = awaited.pop_front();
      if (g.key != w.key) report("group_key", g.key, w.key);
      if (g.size != w.size) report("group_size", g.size, w.size);
      for (int j = 0; j < 3; j++) begin
        if (g.mean[j] != w.mean[j]) report($sformatf("mean %0d", j), g.mean[j], w.mean[j]);
        if (g.spread[j] != w.spread[j])
          report($sformatf("spread %0d", j), g.spread[j], w.spread[j]);
      end
      if (g.ovf != w.ovf) report("count_overflow", g.ovf, w.ovf);
      if (g.is_last != w.is_last) report("last_group", g.is_last, w.is_last);
    endtask
  endclass

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 3000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] row_key_i = 0;
  logic signed [23:0] value_a_i = 0;
  logic signed [23:0] value_b_i = 0;
  logic signed [23:0] value_c_i = 0;
  logic               final_row_i = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] group_key_o;
  logic [15:0]        group_size_o;
  logic signed [23:0] mean_a_o, mean_b_o, mean_c_o;
  logic [23:0]        spread_a_o, spread_b_o, spread_c_o;
  logic               count_overflow_o;
  logic               last_group_o;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = 0;

  group_stats_board board = new();
  int  rows_sent;
  int  burst_left;
  bit  no_gaps;
  bit  hold_request;
  int  idle_cycles;
  bit [31:0] run_key;

  sorted_run_group_mean_stdev uut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .row_key_i, .value_a_i, .value_b_i,
    .value_c_i, .final_row_i, .out_valid, .out_stall, .group_key_o, .group_size_o,
    .mean_a_o, .mean_b_o, .mean_c_o, .spread_a_o, .spread_b_o, .spread_c_o,
    .count_overflow_o, .last_group_o, .cfg_valid, .cfg_ready, .cfg_data
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: checks results and stalls on its own pattern, with one long hold.
  always @(posedge clk_i) begin
    group_t g;
    int hold_left;
    int mode;
    if (out_valid && !out_stall) begin
      g.key = group_key_o;
      g.size = group_size_o;
      g.mean[0] = mean_a_o;
      g.mean[1] = mean_b_o;
      g.mean[2] = mean_c_o;
      g.spread[0] = spread_a_o;
      g.spread[1] = spread_b_o;
      g.spread[2] = spread_c_o;
      g.ovf = count_overflow_o;
      g.is_last = last_group_o;
      board.check_group(g);
    end
    if (hold_request) begin
      hold_request <= 0;
      hold_left = HoldCycles;
    end
    if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (mode == 0) begin
      out_stall <= 0;
    end else if (mode == 1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no progress for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one row and wait until it is taken, then maybe leave a gap.
  task send_row(row_t r);
    int gap;
    in_valid <= 1;
    row_key_i <= r.key;
    value_a_i <= r.val[0];
    value_b_i <= r.val[1];
    value_c_i <= r.val[2];
    final_row_i <= r.fin;
    do @(posedge clk_i); while (in_stall);
    board.note_row(r);
    rows_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_gaps) begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task send(bit [31:0] k, bit [23:0] a, bit [23:0] b, bit [23:0] c, bit f);
    row_t r;
    r.key = k;
    r.val[0] = a;
    r.val[1] = b;
    r.val[2] = c;
    r.fin = f;
    send_row(r);
  endtask

  // Wait for all groups, then write the column count.
  task set_columns(bit [1:0] n);
    in_valid <= 0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_valid <= 1;
    cfg_data <= n;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 0;
    board.cols = n;
  endtask

  function bit [23:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 200)) - 100);
      2: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(0, 8191));
    endcase
  endfunction

  // Mostly sorted runs of equal keys; some noise and out-of-order keys.
  task random_rows(int count);
    row_t r;
    int run_len;
    for (int i = 0; i < count; i++) begin
      if (run_len == 0) begin
        run_len = $urandom_range(1, 6);
        case ($urandom_range(0, 9))
          0: run_key = $urandom();
          1: run_key = run_key - $urandom_range(1, 3);
          default: run_key = run_key + $urandom_range(1, 1000);
        endcase
      end
      run_len--;
      r.key = run_key;
      for (int j = 0; j < 3; j++) r.val[j] = rand_value();
      r.fin = (i == count - 1) || ($urandom_range(0, 29) == 0);
      send_row(r);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed rows: extremes, single rows, two groups from one row, repeats.
    set_columns(2'd3);
    send(32'h80000000, 24'h800000, 24'h800000, 24'h800000, 1);
    send(32'h7FFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
    send(32'h7FFFFFFF, 24'h800000, 24'h800000, 24'h800000, 0);
    send(32'h7FFFFFFF, 24'h000000, 24'h000001, 24'hFFFFFF, 0);
    send(32'hFFFFFFFB, 24'h001000, 24'hFFF000, 24'h000000, 0);
    send(32'hFFFFFFFB, 24'h003000, 24'hFFD000, 24'h000000, 0);
    send(32'd100, 24'h000123, 24'h000456, 24'h000789, 1);
    send(32'd7, 24'hFFFFFF, 24'h000001, 24'h000002, 0);
    send(32'd9, 24'h000005, 24'h000006, 24'h000007, 0);
    send(32'd7, 24'h000008, 24'h000009, 24'h00000A, 0);
    send(32'd7, 24'h00000B, 24'h00000C, 24'h00000D, 1);
    set_columns(2'd0);
    send(32'd1, 24'h000001, 24'h000002, 24'h000003, 0);
    send(32'd1, 24'h000004, 24'h000005, 24'h000006, 0);
    send(32'd2, 24'h000007, 24'h000008, 24'h000009, 1);

    // Random phases across all column settings, with one long output hold.
    random_rows(150);
    set_columns(2'd1);
    random_rows(200);
    set_columns(2'd2);
    hold_request = 1;
    random_rows(200);
    set_columns(2'd3);
    random_rows(250);
    in_valid <= 0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
    $display("run covered %0d rows and %0d groups over column counts 0 to 3,",
             rows_sent, board.groups_seen);
    $display("including extreme values, out-of-order keys and a long output hold.");
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/srg_pkg.sv
design/srg_datapath.sv
design/srg_ctrl.sv
design/sorted_run_group_mean_stdev.sv
tb/sv/tb.sv
